### rtl/mvma_pkg.sv
// Shared constants and types for the matrix-vector multiply-accumulate unit.
// No dependencies.
package mvma_pkg;

    localparam int MAX_COLUMNS  = 1024;
    localparam int ELEMENT_BITS = 16;

    localparam int COL_AW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CFG_COL_W = 11;
    localparam int CFG_ROW_W = 16;
    localparam int GAIN_W    = 16;
    localparam int Y_W       = 32;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;
    localparam int CMP_W     = (CFG_COL_W > COL_AW + 1) ? CFG_COL_W : COL_AW + 1;

    localparam int ACC_BITS  = 48;
    localparam int ACC_FRAC  = 30;
    localparam int ACC_HALF  = ACC_BITS / 2;
    localparam int PROD_W    = 2 * ELEMENT_BITS;
    localparam int PROD_FRAC = 2 * (ELEMENT_BITS - 1);
    localparam int PROD_DOWN = (PROD_FRAC > ACC_FRAC) ? PROD_FRAC - ACC_FRAC : 0;
    localparam int PROD_UP   = (PROD_FRAC < ACC_FRAC) ? ACC_FRAC - PROD_FRAC : 0;
    localparam int EXT_W     = (PROD_W > ACC_BITS) ? PROD_W : ACC_BITS;

    localparam int PLO_W     = GAIN_W + ACC_HALF + 1;
    localparam int PHI_W     = GAIN_W + ACC_HALF;
    localparam int BY_W      = GAIN_W + Y_W;
    localparam int BY_SHIFT  = 14;
    localparam int TOT_W     = 66;
    localparam int RND_SHIFT = 25;
    localparam int OUT_SHIFT = 26;
    localparam int SH_W      = TOT_W - OUT_SHIFT;

    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_GAIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BETA_GAIN    = 3'd3;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MAC  = 5'b00010,
        ST_FIN1 = 5'b00100,
        ST_FIN2 = 5'b01000,
        ST_FIN3 = 5'b10000
    } t_state;

endpackage

### rtl/matrix_vector_multiply_accumulate_unit.sv
// Matrix-vector multiply-accumulate unit: y = beta*y + alpha*(A*x), row by row.
// Depends on mvma_pkg; holds the x vector store and the accumulate/scale sequencer.
//
//   channel | direction | handshake                    | payload
//   in      | input     | i_in_valid / o_in_ready      | i_mode, i_element, i_y_in
//   out     | output    | o_out_valid / i_out_ready    | o_y_out, o_row_index, o_last_row,
//           |           |                              | o_saturated
//   cfg     | input     | i_cfg_we                     | i_cfg_index, i_cfg_data
//
// A load item writes the x store; a matrix item reads the x store, then does MAC.
// The last item of a row goes through MAC, then two passes of the 16x25 alpha
// multiplier over the 48-bit sum, then round and saturate into the output register.
// The output register holds a result while new items are taken; the final step of
// the next row waits only if that register is still full.
// Reset is synchronous; the x store has no reset and no clearing pass.
module matrix_vector_multiply_accumulate_unit import mvma_pkg::*; (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DAT_W-1:0]         i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic                         i_mode,
    input  logic signed [ELEMENT_BITS-1:0] i_element,
    input  logic signed [Y_W-1:0]        i_y_in,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [Y_W-1:0]        o_y_out,
    output logic [CFG_ROW_W-1:0]         o_row_index,
    output logic                         o_last_row,
    output logic                         o_saturated
);

    t_state                         r_state, n_state;
    logic [CFG_COL_W-1:0]           r_col_cnt;
    logic [CFG_ROW_W-1:0]           r_row_cnt;
    logic signed [GAIN_W-1:0]       r_alpha, r_beta;
    logic [COL_AW-1:0]              r_load_pos, n_load_pos;
    logic [COL_AW-1:0]              r_col_pos, n_col_pos;
    logic [CFG_ROW_W-1:0]           r_row_pos, n_row_pos;
    logic signed [ACC_BITS-1:0]     r_acc, n_acc;
    logic                           r_out_valid, n_out_valid;

    logic [ELEMENT_BITS-1:0]        r_vec_mem [MAX_COLUMNS];
    logic signed [ELEMENT_BITS-1:0] r_x_rd;
    logic signed [ELEMENT_BITS-1:0] r_elem;
    logic signed [Y_W-1:0]          r_y_in;
    logic                           r_row_end;
    logic signed [PLO_W-1:0]        r_p_lo;
    logic signed [BY_W-1:0]         r_by;
    logic signed [PHI_W-1:0]        r_p_hi;
    logic signed [TOT_W-1:0]        r_part;
    logic signed [Y_W-1:0]          r_y_out;
    logic [CFG_ROW_W-1:0]           r_row_idx;
    logic                           r_last_row, r_sat;

    logic                           in_acc, out_acc, mem_we, mem_re, fin_go;
    logic [CMP_W-1:0]               col_cnt_ext, n_eff, load_inc, col_inc;
    logic [CFG_ROW_W-1:0]           m_eff;
    logic [CFG_ROW_W:0]             row_inc;
    logic                           row_last;
    logic signed [PROD_W-1:0]       prod;
    logic signed [EXT_W-1:0]        prod_ext, prod_al;
    logic signed [PLO_W-1:0]        p_lo;
    logic signed [PHI_W-1:0]        p_hi;
    logic signed [BY_W-1:0]         by;
    logic signed [TOT_W-1:0]        part, total;
    logic signed [SH_W-1:0]         sh;
    logic                           ovf;
    logic signed [Y_W-1:0]          y_sat;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_acc    = r_out_valid && i_out_ready;
    assign mem_we     = in_acc && !i_mode;
    assign mem_re     = in_acc && i_mode;
    assign fin_go     = (r_state == ST_FIN3) && (!r_out_valid || i_out_ready);

    // effective counts
    always_comb begin
        col_cnt_ext = CMP_W'(r_col_cnt);
        if (col_cnt_ext == '0) begin
            n_eff = CMP_W'(1);
        end else if (col_cnt_ext > CMP_W'(MAX_COLUMNS)) begin
            n_eff = CMP_W'(MAX_COLUMNS);
        end else begin
            n_eff = col_cnt_ext;
        end
        m_eff    = (r_row_cnt == '0) ? CFG_ROW_W'(1) : r_row_cnt;
        load_inc = CMP_W'(r_load_pos) + CMP_W'(1);
        col_inc  = CMP_W'(r_col_pos) + CMP_W'(1);
        row_inc  = {1'b0, r_row_pos} + (CFG_ROW_W + 1)'(1);
        row_last = (row_inc >= {1'b0, m_eff});
    end

    // datapath
    always_comb begin
        prod     = r_elem * r_x_rd;
        prod_ext = EXT_W'(prod);
        if (PROD_FRAC > ACC_FRAC) begin
            prod_al = prod_ext >>> PROD_DOWN;
        end else begin
            prod_al = prod_ext <<< PROD_UP;
        end
        p_lo  = r_alpha * $signed({1'b0, r_acc[ACC_HALF-1:0]});
        p_hi  = r_alpha * $signed(r_acc[ACC_BITS-1:ACC_HALF]);
        by    = r_beta * r_y_in;
        part  = TOT_W'(r_p_lo) + (TOT_W'(r_by) <<< BY_SHIFT);
        total = (TOT_W'(r_p_hi) <<< ACC_HALF) + r_part + (TOT_W'(1) <<< RND_SHIFT);
        sh    = total[TOT_W-1:OUT_SHIFT];
        ovf   = (sh[SH_W-1:Y_W-1] != '0) && (sh[SH_W-1:Y_W-1] != '1);
        if (!ovf) begin
            y_sat = sh[Y_W-1:0];
        end else if (sh[SH_W-1]) begin
            y_sat = {1'b1, {(Y_W-1){1'b0}}};
        end else begin
            y_sat = {1'b0, {(Y_W-1){1'b1}}};
        end
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_load_pos  = r_load_pos;
        n_col_pos   = r_col_pos;
        n_row_pos   = r_row_pos;
        n_acc       = r_acc;
        n_out_valid = r_out_valid && !out_acc;
        case (r_state)
            ST_IDLE: begin
                if (mem_we) begin
                    n_load_pos = (load_inc >= n_eff) ? '0 : load_inc[COL_AW-1:0];
                end
                if (mem_re) begin
                    n_state = ST_MAC;
                end
            end
            ST_MAC: begin
                n_acc = r_acc + prod_al[ACC_BITS-1:0];
                if (col_inc >= n_eff) begin
                    n_col_pos = '0;
                    n_state   = ST_FIN1;
                end else begin
                    n_col_pos = col_inc[COL_AW-1:0];
                    n_state   = ST_IDLE;
                end
            end
            ST_FIN1: n_state = ST_FIN2;
            ST_FIN2: n_state = ST_FIN3;
            ST_FIN3: begin
                if (fin_go) begin
                    n_acc       = '0;
                    n_row_pos   = row_last ? '0 : row_inc[CFG_ROW_W-1:0];
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_col_cnt   <= CFG_COL_W'(1);
            r_row_cnt   <= CFG_ROW_W'(1);
            r_alpha     <= GAIN_W'(4096);
            r_beta      <= '0;
            r_load_pos  <= '0;
            r_col_pos   <= '0;
            r_row_pos   <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_load_pos  <= n_load_pos;
            r_col_pos   <= n_col_pos;
            r_row_pos   <= n_row_pos;
            r_acc       <= n_acc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_COLUMN_COUNT: r_col_cnt <= i_cfg_data[CFG_COL_W-1:0];
                    CFG_ROW_COUNT:    r_row_cnt <= i_cfg_data[CFG_ROW_W-1:0];
                    CFG_ALPHA_GAIN:   r_alpha   <= $signed(i_cfg_data[GAIN_W-1:0]);
                    CFG_BETA_GAIN:    r_beta    <= $signed(i_cfg_data[GAIN_W-1:0]);
                    default: ;
                endcase
            end
        end
    end

    // x vector store
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vec_mem[r_load_pos] <= i_element;
        end
        if (mem_re) begin
            r_x_rd <= $signed(r_vec_mem[r_col_pos]);
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_elem <= i_element;
            r_y_in <= i_y_in;
        end
        if (r_state == ST_FIN1) begin
            r_p_lo <= p_lo;
            r_by   <= by;
        end
        if (r_state == ST_FIN2) begin
            r_p_hi <= p_hi;
            r_part <= part;
        end
        if (fin_go) begin
            r_y_out    <= y_sat;
            r_sat      <= ovf;
            r_row_idx  <= r_row_pos;
            r_last_row <= row_last;
        end
        r_row_end <= (r_state == ST_MAC) && (col_inc >= n_eff);
    end

    assign o_out_valid = r_out_valid;
    assign o_y_out     = r_y_out;
    assign o_row_index = r_row_idx;
    assign o_last_row  = r_last_row;
    assign o_saturated = r_sat;

    a_mac_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_re |=> (r_state == ST_MAC))
        else $error("matrix item did not enter MAC");

    a_load_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> (r_state == ST_IDLE))
        else $error("load item left idle");

    a_row_end_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row_end |-> (r_state == ST_FIN1))
        else $error("row end did not start scaling");

    a_result_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (r_out_valid && r_acc == '0))
        else $error("result not posted or sum not cleared");

    a_sat_extreme: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
            (o_y_out == {1'b0, {(Y_W-1){1'b1}}} || o_y_out == {1'b1, {(Y_W-1){1'b0}}}))
        else $error("saturated flag without clipped value");

endmodule
